// ===== src/pwt_pkg.sv =====
package pwt_pkg;

    // result status codes
    typedef enum logic [1:0] {
        STATUS_TOKEN = 2'd0,
        STATUS_ERROR = 2'd1,
        STATUS_END   = 2'd2
    } status_t;

    // symbol set selection
    localparam logic [1:0] MODE_JSON = 2'd0;
    localparam logic [1:0] MODE_DOT  = 2'd1;

    // token kinds
    localparam logic KIND_WORD   = 1'b0;
    localparam logic KIND_SYMBOL = 1'b1;

    // characters of interest
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_APOS   = 8'h27;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_EQUALS = 8'h3D;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_UNDER  = 8'h5F;

    // one result item
    typedef struct packed {
        status_t     status;
        logic [7:0]  char_code;
        logic        token_start;
        logic        token_kind;
        logic [15:0] line_number;
        logic [15:0] column_number;
        logic        last_of_run;
    } result_t;

endpackage

// ===== src/pwt_lexer.sv =====
module pwt_lexer #(
    parameter int POSITION_BITS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    input  logic [1:0]        cfg_data,
    input  logic              accept,
    input  logic [7:0]        text_byte,
    input  logic              end_of_text,
    output logic [1:0]        push_count,
    output pwt_pkg::result_t  result0,
    output pwt_pkg::result_t  result1
);
    import pwt_pkg::*;

    localparam int PB  = POSITION_BITS;
    localparam int EXT = (PB > 16) ? PB : 16;

    logic [1:0]    mode_reg;
    logic [PB-1:0] line_reg, line_next;
    logic [PB-1:0] col_reg, col_next;
    logic          word_reg, word_next;
    logic          dash_reg, dash_next;
    logic          halted_reg, halted_next;
    logic [1:0]    count;
    logic          is_word;
    logic [15:0]   line_out, col_out;

    // saturating position increment
    function automatic logic [PB-1:0] sat_inc(input logic [PB-1:0] v, input logic [1:0] by);
        logic [PB:0] s;
        s = {1'b0, v} + {{(PB - 1){1'b0}}, by};
        return s[PB] ? {PB{1'b1}} : s[PB-1:0];
    endfunction

    // clip a position to the 16 bit result field
    function automatic logic [15:0] clip16(input logic [PB-1:0] v);
        logic [EXT-1:0] e;
        e = EXT'(v);
        return (e > EXT'(16'hFFFF)) ? 16'hFFFF : e[15:0];
    endfunction

    // single character symbols of the selected set
    function automatic logic in_set(input logic [1:0] m, input logic [7:0] c);
        logic brace;
        brace = (c == CH_LBRACE) || (c == CH_RBRACE) || (c == CH_LBRACK) || (c == CH_RBRACK);
        if (m == MODE_JSON)
            return brace || (c == CH_COLON) || (c == CH_COMMA) || (c == CH_APOS)
                || (c == CH_DOT);
        else if (m == MODE_DOT)
            return brace || (c == CH_QUOTE) || (c == CH_EQUALS) || (c == CH_SEMI);
        else
            return 1'b0;
    endfunction

    assign is_word = ((text_byte >= 8'h61) && (text_byte <= 8'h7A))
                  || ((text_byte >= 8'h41) && (text_byte <= 8'h5A))
                  || ((text_byte >= 8'h30) && (text_byte <= 8'h39))
                  || (text_byte == CH_UNDER);

    assign line_out = clip16(line_reg);
    assign col_out  = clip16(col_reg);

    // per item decode and next state
    always_comb begin
        line_next   = line_reg;
        col_next    = col_reg;
        word_next   = word_reg;
        dash_next   = dash_reg;
        halted_next = halted_reg;
        count       = 2'd0;
        result0     = '0;
        result1     = '0;
        result0.line_number   = line_out;
        result0.column_number = col_out;
        result1.line_number   = line_out;
        result1.column_number = col_out;
        if (!halted_reg) begin
            if (dash_reg) begin
                dash_next = 1'b0;
                if (!end_of_text && (text_byte == CH_GT)) begin
                    count                = 2'd2;
                    result0.char_code    = CH_DASH;
                    result0.token_start  = 1'b1;
                    result0.token_kind   = KIND_SYMBOL;
                    result1.char_code    = CH_GT;
                    result1.token_kind   = KIND_SYMBOL;
                    col_next             = sat_inc(col_reg, 2'd2);
                end else begin
                    count          = 2'd1;
                    result0.status = STATUS_ERROR;
                    halted_next    = 1'b1;
                end
            end else if (end_of_text) begin
                count          = 2'd1;
                result0.status = STATUS_END;
                line_next      = PB'(1);
                col_next       = PB'(1);
                word_next      = 1'b0;
            end else if (is_word) begin
                count               = 2'd1;
                result0.char_code   = text_byte;
                result0.token_start = !word_reg;
                result0.token_kind  = KIND_WORD;
                word_next           = 1'b1;
                col_next            = sat_inc(col_reg, 2'd1);
            end else begin
                word_next = 1'b0;
                if ((text_byte == CH_CR) || (text_byte == CH_LF)) begin
                    line_next = sat_inc(line_reg, 2'd1);
                    col_next  = PB'(1);
                end else if (text_byte == CH_SPACE) begin
                    col_next = sat_inc(col_reg, 2'd1);
                end else if (text_byte[7]) begin
                    // high bytes are skipped
                end else if ((mode_reg == MODE_DOT) && (text_byte == CH_DASH)) begin
                    dash_next = 1'b1;
                end else if (in_set(mode_reg, text_byte)) begin
                    count               = 2'd1;
                    result0.char_code   = text_byte;
                    result0.token_start = 1'b1;
                    result0.token_kind  = KIND_SYMBOL;
                    col_next            = sat_inc(col_reg, 2'd1);
                end else begin
                    count          = 2'd1;
                    result0.status = STATUS_ERROR;
                    halted_next    = 1'b1;
                end
            end
        end
        result0.last_of_run = (count == 2'd1);
        result1.last_of_run = 1'b1;
    end

    assign push_count = accept ? count : 2'd0;

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_JSON;
            line_reg   <= PB'(1);
            col_reg    <= PB'(1);
            word_reg   <= 1'b0;
            dash_reg   <= 1'b0;
            halted_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                mode_reg <= cfg_data;
            end
            if (accept) begin
                line_reg   <= line_next;
                col_reg    <= col_next;
                word_reg   <= word_next;
                dash_reg   <= dash_next;
                halted_reg <= halted_next;
            end
        end
    end

endmodule

// ===== src/pwt_result_queue.sv =====
module pwt_result_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [1:0]        push_count,
    input  pwt_pkg::result_t  din0,
    input  pwt_pkg::result_t  din1,
    output logic              room,
    output logic              out_valid,
    input  logic              out_ready,
    output pwt_pkg::result_t  dout
);
    import pwt_pkg::*;

    localparam int DEPTH = 4;

    result_t    mem [DEPTH];
    logic [1:0] wr_ptr_reg, rd_ptr_reg;
    logic [2:0] count_reg, count_next;
    logic       pop;

    assign out_valid = (count_reg != 3'd0);
    assign pop       = out_valid && out_ready;
    assign room      = (count_reg <= 3'(DEPTH - 2));
    assign dout      = mem[rd_ptr_reg];

    assign count_next = count_reg + {1'b0, push_count} - {2'b00, pop};

    // entry storage, up to two writes per cycle
    always_ff @(posedge aclk) begin
        if (push_count != 2'd0) begin
            mem[wr_ptr_reg] <= din0;
        end
        if (push_count == 2'd2) begin
            mem[wr_ptr_reg + 2'd1] <= din1;
        end
    end

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + push_count;
            rd_ptr_reg <= rd_ptr_reg + {1'b0, pop};
            count_reg  <= count_next;
        end
    end

endmodule

// ===== src/punctuation_word_tokenizer.sv =====
// results are queued as their item is accepted and are offered on the m_ side
// one item per cycle while s_tready is high; an arrow gives two results from one item
// a four entry result queue sits between lexer state and output; s_tready is low
// while fewer than two entries are free, so a stalled output backs up the input
// reset: synchronous, active low; position back to line 1 column 1, mode JSON-style,
// queue empty, no pending dash, not halted
module punctuation_word_tokenizer #(
    parameter int POSITION_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // text_byte
    input  logic        s_tlast,   // end_of_text
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // char_code, line_number, column_number
    output logic [3:0]  m_tuser,   // status, token_start, token_kind
    output logic        m_tlast    // last_of_run
);
    import pwt_pkg::*;

    logic       accept;
    logic       room;
    logic [1:0] push_count;
    result_t    res0, res1, head;

    assign cfg_ready = 1'b1;
    assign s_tready  = room;
    assign accept    = s_tvalid && room;

    pwt_lexer #(
        .POSITION_BITS(POSITION_BITS)
    ) u_lexer (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_data    (cfg_data),
        .accept      (accept),
        .text_byte   (s_tdata),
        .end_of_text (s_tlast),
        .push_count  (push_count),
        .result0     (res0),
        .result1     (res1)
    );

    pwt_result_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_count (push_count),
        .din0       (res0),
        .din1       (res1),
        .room       (room),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .dout       (head)
    );

    // pack the head item onto the output
    assign m_tdata = {head.column_number, head.line_number, head.char_code};
    assign m_tuser = {head.token_kind, head.token_start, head.status};
    assign m_tlast = head.last_of_run;

endmodule
